// ----- hw/rtl/fpba_pkg.sv -----
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types, field widths and codes for the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

   localparam int NUM_BLOCKS_DEF = 16;
   localparam int SIZE_BITS_DEF  = 16;

   localparam int OP_W          = 1;
   localparam int LOAD_INDEX_W  = 4;
   localparam int ITEM_SIZE_W   = 16;
   localparam int CHOSEN_W      = 4;
   localparam int SIZE_LEFT_W   = 16;

   localparam int FIT_MODE_W    = 2;
   localparam int BLOCK_COUNT_W = 5;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 5;

   localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
   localparam logic [OP_W-1:0] OP_REQUEST = 1'b1;

   localparam logic [FIT_MODE_W-1:0] MODE_FIRST = 2'd0;
   localparam logic [FIT_MODE_W-1:0] MODE_NEXT  = 2'd1;
   localparam logic [FIT_MODE_W-1:0] MODE_BEST  = 2'd2;
   localparam logic [FIT_MODE_W-1:0] MODE_WORST = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIT_MODE    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_COUNT = 1'b1;

   localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic [LOAD_INDEX_W-1:0] load_index;
      logic [ITEM_SIZE_W-1:0]  item_size;
   } req_type;

   typedef struct packed {
      logic                   granted;
      logic [CHOSEN_W-1:0]    chosen_block;
      logic [SIZE_LEFT_W-1:0] size_left;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // write one table entry from the request word
      logic start;   // latch request, clear search state, set scan start
      logic issue;   // read one entry and step the scan
      logic commit;  // charge the chosen block and load the result word
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last;       // scan is on its final entry
      logic cnt_zero;   // no entries in use
      logic out_free;   // result register can take a word
   } stat_type;

endpackage

// ----- hw/rtl/fit_policy_block_allocator.sv -----
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Block allocator with first, next, best and worst fit over a free-size table.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel (valid/stall): a load word writes one free size and returns
//   the next-fit pointer to entry 0; it gives no result.
//   A request word searches the entries in use and charges the chosen block.
//   rsp_ channel (valid/stall): one word per request (granted, block, size
//   left); zeros when nothing fits.
//   csr_ channel (valid/ready, always ready): index 0 fit mode, 1 block count.
//   Write it only while the block is idle.
// Timing: a request walks the table one entry per cycle through the table
//   RAM read port; a drain step then compares the last word read and the
//   commit step loads the result register, and the next word is taken
//   once the commit is done. With no entries in use a request goes
//   straight to the commit step.
// Reset: table reads as all zero (per-entry valid bits), pointer 0, fit mode
//   first fit, block count 16. No clearing pass.
// Stall: the result register holds its word; the block takes the next word
//   meanwhile, and a request that finishes while it is still full waits in
//   the commit step until it drains.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator #(
   parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
   parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  fpba_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output fpba_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fpba_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fpba_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fpba_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   fpba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   fpba_dpath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a result word is never overwritten while it is stalled
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || !rsp_stall))
      else $error("commit into a stalled result word");

   // refused requests report zeros
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.granted) |-> (rsp_data.chosen_block == '0 &&
                                            rsp_data.size_left == '0))
      else $error("refused request with nonzero fields");

   // a request holds off the next word until it commits
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.op == OP_REQUEST) |=> req_stall)
      else $error("new word taken during a search");

   // a load produces no result word
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.op == OP_LOAD && !rsp_valid) |=> !rsp_valid)
      else $error("load produced a result");

endmodule

// ----- hw/rtl/fpba_ram.sv -----
// ----------------------------------------------------------------------------
// fpba_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fpba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/fpba_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpba_ctrl
// Sequencer: takes one word; a load is written at once, a request runs the table scan, then commits the result.
// ----------------------------------------------------------------------------
module fpba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_op,
   output logic               req_stall,
   input  fpba_pkg::stat_type stat,
   output fpba_pkg::cmd_type  cmd
);
   import fpba_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_REQUEST) begin
                  cmd.start = 1'b1;
                  state_in  = stat.cnt_zero ? S_COMMIT : S_SCAN;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
            if (stat.last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last read data is compared here
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/fpba_dpath.sv -----
// ----------------------------------------------------------------------------
// fpba_dpath
// Free-size table, config registers, scan compare and result register.
// ----------------------------------------------------------------------------
module fpba_dpath #(
   parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
   parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fpba_pkg::req_type                    req_data,
   input  logic                                 csr_valid,
   input  logic [fpba_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fpba_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  fpba_pkg::cmd_type                    cmd,
   output fpba_pkg::stat_type                   stat,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output fpba_pkg::rsp_type                    rsp_data
);
   import fpba_pkg::*;

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int AC_W  = (CNT_W > BLOCK_COUNT_W) ? CNT_W : BLOCK_COUNT_W;
   localparam int CMP_W = (SIZE_BITS > ITEM_SIZE_W) ? SIZE_BITS : ITEM_SIZE_W;

   // config
   logic [FIT_MODE_W-1:0]    fit_mode_ff;
   logic [BLOCK_COUNT_W-1:0] block_count_ff;
   logic [CNT_W-1:0]         cnt;

   // scan state
   logic [ITEM_SIZE_W-1:0] size_ff;
   logic [IDX_W-1:0]       addr_ff, addr_in, addr_step;
   logic [CNT_W-1:0]       j_ff, j_in;
   logic [IDX_W-1:0]       ptr_ff, ptr_in;
   logic                   rd_valid_ff;
   logic [IDX_W-1:0]       rd_addr_ff;
   logic                   vld_rd_ff;
   logic [NUM_BLOCKS-1:0]  vld_ff, vld_in;

   // search result
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       pick_ff, pick_in;
   logic [SIZE_BITS-1:0]   best_ff, best_in;

   // table access
   logic [SIZE_BITS-1:0]   ram_rdata, entry;
   logic                   wr_en, load_ok;
   logic [IDX_W-1:0]       wr_addr, load_addr;
   logic [SIZE_BITS-1:0]   wr_data;
   logic [CMP_W-1:0]       entry_ext, size_ext, diff;
   logic                   fits, take;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   assign cnt = (AC_W'(block_count_ff) > AC_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                             : CNT_W'(block_count_ff);

   assign stat.last     = (j_ff == cnt - CNT_W'(1));
   assign stat.cnt_zero = (cnt == '0);
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff    <= MODE_FIRST;
         block_count_ff <= BLOCK_COUNT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FIT_MODE:    fit_mode_ff    <= csr_wdata[FIT_MODE_W-1:0];
            CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[BLOCK_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // scan address: cyclic over the entries in use
   assign addr_step = ((CNT_W'(addr_ff) + CNT_W'(1)) < cnt) ? addr_ff + IDX_W'(1) : '0;

   always_comb begin
      addr_in = addr_ff;
      j_in    = j_ff;
      if (cmd.start) begin
         j_in = '0;
         if (fit_mode_ff == MODE_NEXT && CNT_W'(ptr_ff) < cnt) begin
            addr_in = ptr_ff;
         end else begin
            addr_in = '0;
         end
      end else if (cmd.issue) begin
         j_in    = j_ff + CNT_W'(1);
         addr_in = addr_step;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      j_ff       <= j_in;
      rd_addr_ff <= addr_ff;
      vld_rd_ff  <= vld_ff[addr_ff];
      if (cmd.start) begin
         size_ff <= req_data.item_size;
      end
   end

   // compare the word read last cycle
   assign entry     = vld_rd_ff ? ram_rdata : '0;
   assign entry_ext = CMP_W'(entry);
   assign size_ext  = CMP_W'(size_ff);
   assign fits      = (entry_ext >= size_ext);

   always_comb begin
      take = 1'b0;
      if (rd_valid_ff && fits) begin
         if (!found_ff) begin
            take = 1'b1;
         end else if (fit_mode_ff == MODE_BEST) begin
            take = (entry < best_ff);
         end else if (fit_mode_ff == MODE_WORST) begin
            take = (entry > best_ff);
         end
      end
   end

   always_comb begin
      found_in = found_ff;
      pick_in  = pick_ff;
      best_in  = best_ff;
      if (cmd.start) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         pick_in  = rd_addr_ff;
         best_in  = entry;
      end
   end

   assign diff = CMP_W'(best_ff) - size_ext;

   // table writes: load word or charge of the chosen block
   assign load_addr = IDX_W'(req_data.load_index);
   assign load_ok   = (int'(req_data.load_index) < NUM_BLOCKS);
   assign wr_en     = (cmd.load && load_ok) || (cmd.commit && found_ff);
   assign wr_addr   = cmd.commit ? pick_ff : load_addr;
   assign wr_data   = cmd.commit ? SIZE_BITS'(diff) : SIZE_BITS'(req_data.item_size);

   always_comb begin
      vld_in = vld_ff;
      if (cmd.load && load_ok) begin
         vld_in[load_addr] = 1'b1;
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = '0;
      end else if (cmd.commit && found_ff && fit_mode_ff == MODE_NEXT) begin
         ptr_in = pick_ff;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in         = 1'b1;
         rsp_in.granted       = found_ff;
         rsp_in.chosen_block  = found_ff ? CHOSEN_W'(pick_ff) : '0;
         rsp_in.size_left     = found_ff ? SIZE_LEFT_W'(diff) : '0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         ptr_ff       <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= cmd.issue;
         found_ff     <= found_in;
         ptr_ff       <= ptr_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pick_ff <= pick_in;
      best_ff <= best_in;
      rsp_ff  <= rsp_in;
   end

   fpba_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.issue),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
